// ----- rtl/core/uopc_pkg.sv -----
// ----------------------------------------------------------------------------
// uopc_pkg: shared types and constants
// Fixed-point constants, the Taylor step record and the divider step record
// used by the offset-point unicycle controller.
// ----------------------------------------------------------------------------
package uopc_pkg;

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [33:0] PI_Q32 = 34'd13493037705;
	localparam logic [15:0] QUARTER = 16'd16384;
	localparam int TAYLOR_STEPS = 6;
	localparam int DIV_STEPS = 32;
	localparam int LANE_LAT = 2 + 3 * TAYLOR_STEPS + 2;

	localparam logic REG_PROP_GAIN = 1'b0;
	localparam logic REG_POINT_OFFSET = 1'b1;

	typedef struct packed {
		logic [30:0] x;
		logic [31:0] x2;
		logic [30:0] r;
		logic neg;
	} taylor_t;

	typedef struct packed {
		logic [15:0] rem;
		logic [31:0] word;
		logic [15:0] dv;
		logic neg;
		logic ovf;
		logic signed [31:0] fw;
		logic fw_hit;
	} div_t;

	function automatic int taylor_div(input int step);
		int k;
		k = 12 - 2 * step;
		return k * (k + 1);
	endfunction

endpackage

// ----- rtl/core/unicycle_offset_point_controller.sv -----
// ----------------------------------------------------------------------------
// unicycle_offset_point_controller: offset-point unicycle tracking controller
// From start to done a command passes the sine chains, the error and Jacobian
// stages, the divider chain and an output register.
// Throughput is one item per cycle; busy stays low and results cannot stall.
// Reset restores both configuration registers and clears the valid pipeline.
// ----------------------------------------------------------------------------
module unicycle_offset_point_controller
	import uopc_pkg::*;
#(
	parameter int TRIG_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] goal_x,
	input  logic signed [31:0] goal_y,
	input  logic [15:0]        goal_heading,
	input  logic signed [31:0] meas_x,
	input  logic signed [31:0] meas_y,
	input  logic [15:0]        meas_heading,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               done,
	output logic signed [31:0] forward_speed,
	output logic signed [31:0] turn_rate,
	output logic               clipped
);

	localparam int TW = TRIG_BITS + 2;
	localparam int PW = TW + 17;
	localparam int DW = 22;
	localparam int EW = 34;
	localparam int KW = 51;
	localparam int VW = 38;
	localparam int MW = TW + VW;
	localparam int SW = MW + 1;
	localparam int FW = 40;
	localparam int TOTAL = LANE_LAT + 7 + DIV_STEPS;
	localparam logic signed [PW-1:0] RD = PW'(64'd1 << (TRIG_BITS - 5));
	localparam logic signed [SW-1:0] RT = SW'(64'd1 << (TRIG_BITS - 1));
	localparam logic signed [FW-1:0] MAX32 = FW'(64'sd2147483647);
	localparam logic signed [FW-1:0] MIN32 = -FW'(64'sd2147483648);

	typedef struct packed {
		logic signed [31:0] gx;
		logic signed [31:0] gy;
		logic signed [31:0] mx;
		logic signed [31:0] my;
	} pos_t;

	logic [15:0] prop_gain_q, point_offset_q;
	logic [15:0] dv;
	logic [TOTAL-1:0] vld_q;
	pos_t pos_q [LANE_LAT];

	logic signed [TW-1:0] cg, sg, cm, sm;

	logic signed [PW-1:0] pcg_s1, psg_s1, pcm_s1, psm_s1;
	pos_t pos_s1;
	logic signed [TW-1:0] cm_s1, sm_s1, cm_s2, sm_s2, cm_s3, sm_s3, cm_s4, sm_s4;
	logic signed [PW-1:0] rcg, rsg, rcm, rsm;
	logic signed [EW-1:0] ex_s2, ey_s2;
	logic signed [KW-1:0] kex_s3, key_s3, rkx, rky;
	logic signed [VW-1:0] vx_s4, vy_s4;
	logic signed [MW-1:0] pa_s5, pb_s5, pc_s5, pe_s5;
	logic signed [SW-1:0] sfw, snum;
	logic signed [FW-1:0] fw_s6, num_s6;
	logic [FW-1:0] mag;
	logic [50:0] nabs;
	div_t div_s7;
	div_t chain [DIV_STEPS+1];

	logic [31:0] q;
	logic signed [31:0] turn_v;
	logic turn_hit;
	logic signed [31:0] fw_q, turn_q;
	logic hit_q, done_q;

	assign busy = 1'b0;
	assign dv = (point_offset_q == 16'd0) ? 16'd1 : point_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q <= 16'd2048;
			point_offset_q <= 16'd1229;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP_GAIN: prop_gain_q <= cfg_data;
				REG_POINT_OFFSET: point_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q <= {vld_q[TOTAL-2:0], start};
			done_q <= vld_q[TOTAL-1];
		end
	end

	uopc_sine #(.TRIG_BITS(TRIG_BITS)) u_cg (
		.clk(clk), .angle(goal_heading + QUARTER), .value(cg));
	uopc_sine #(.TRIG_BITS(TRIG_BITS)) u_sg (
		.clk(clk), .angle(goal_heading), .value(sg));
	uopc_sine #(.TRIG_BITS(TRIG_BITS)) u_cm (
		.clk(clk), .angle(meas_heading + QUARTER), .value(cm));
	uopc_sine #(.TRIG_BITS(TRIG_BITS)) u_sm (
		.clk(clk), .angle(meas_heading), .value(sm));

	always_ff @(posedge clk) begin
		pos_q[0] <= '{gx: goal_x, gy: goal_y, mx: meas_x, my: meas_y};
		for (int i = 1; i < LANE_LAT; i++) begin
			pos_q[i] <= pos_q[i-1];
		end
	end

	assign rcg = (pcg_s1 + RD) >>> (TRIG_BITS - 4);
	assign rsg = (psg_s1 + RD) >>> (TRIG_BITS - 4);
	assign rcm = (pcm_s1 + RD) >>> (TRIG_BITS - 4);
	assign rsm = (psm_s1 + RD) >>> (TRIG_BITS - 4);
	assign rkx = (kex_s3 + KW'(2048)) >>> 12;
	assign rky = (key_s3 + KW'(2048)) >>> 12;
	assign sfw = (SW'(pa_s5) + SW'(pb_s5) + RT) >>> TRIG_BITS;
	assign snum = (SW'(pc_s5) - SW'(pe_s5) + RT) >>> TRIG_BITS;
	assign mag = num_s6[FW-1] ? FW'(-num_s6) : FW'(num_s6);
	assign nabs = (51'(mag) << 12) + 51'(dv >> 1);

	always_ff @(posedge clk) begin
		pcg_s1 <= $signed({1'b0, dv}) * cg;
		psg_s1 <= $signed({1'b0, dv}) * sg;
		pcm_s1 <= $signed({1'b0, dv}) * cm;
		psm_s1 <= $signed({1'b0, dv}) * sm;
		pos_s1 <= pos_q[LANE_LAT-1];
		cm_s1 <= cm;
		sm_s1 <= sm;

		ex_s2 <= EW'(pos_s1.gx) + EW'($signed(rcg[DW-1:0]))
			- EW'(pos_s1.mx) - EW'($signed(rcm[DW-1:0]));
		ey_s2 <= EW'(pos_s1.gy) + EW'($signed(rsg[DW-1:0]))
			- EW'(pos_s1.my) - EW'($signed(rsm[DW-1:0]));
		cm_s2 <= cm_s1;
		sm_s2 <= sm_s1;

		kex_s3 <= $signed({1'b0, prop_gain_q}) * ex_s2;
		key_s3 <= $signed({1'b0, prop_gain_q}) * ey_s2;
		cm_s3 <= cm_s2;
		sm_s3 <= sm_s2;

		vx_s4 <= $signed(rkx[VW-1:0]);
		vy_s4 <= $signed(rky[VW-1:0]);
		cm_s4 <= cm_s3;
		sm_s4 <= sm_s3;

		pa_s5 <= cm_s4 * vx_s4;
		pb_s5 <= sm_s4 * vy_s4;
		pc_s5 <= cm_s4 * vy_s4;
		pe_s5 <= sm_s4 * vx_s4;

		fw_s6 <= $signed(sfw[FW-1:0]);
		num_s6 <= $signed(snum[FW-1:0]);

		div_s7.rem <= nabs[47:32];
		div_s7.word <= nabs[31:0];
		div_s7.dv <= dv;
		div_s7.neg <= num_s6[FW-1];
		div_s7.ovf <= nabs[50:32] >= {3'b000, dv};
		div_s7.fw_hit <= (fw_s6 > MAX32) || (fw_s6 < MIN32);
		if (fw_s6 > MAX32) begin
			div_s7.fw <= 32'sh7FFF_FFFF;
		end else if (fw_s6 < MIN32) begin
			div_s7.fw <= 32'sh8000_0000;
		end else begin
			div_s7.fw <= fw_s6[31:0];
		end
	end

	assign chain[0] = div_s7;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		uopc_div_cell u_div (
			.clk (clk),
			.din (chain[i]),
			.dout(chain[i+1])
		);
	end

	assign q = chain[DIV_STEPS].word;

	always_comb begin
		turn_hit = 1'b0;
		turn_v = $signed(q);
		if (chain[DIV_STEPS].neg) begin
			if (chain[DIV_STEPS].ovf || q > 32'h8000_0000) begin
				turn_hit = 1'b1;
				turn_v = 32'sh8000_0000;
			end else begin
				turn_v = -$signed(q);
			end
		end else if (chain[DIV_STEPS].ovf || q[31]) begin
			turn_hit = 1'b1;
			turn_v = 32'sh7FFF_FFFF;
		end
	end

	always_ff @(posedge clk) begin
		fw_q <= chain[DIV_STEPS].fw;
		turn_q <= turn_v;
		hit_q <= turn_hit | chain[DIV_STEPS].fw_hit;
	end

	assign done = done_q;
	assign forward_speed = fw_q;
	assign turn_rate = turn_q;
	assign clipped = hit_q;

endmodule

// ----- rtl/core/uopc_taylor_cell.sv -----
// ----------------------------------------------------------------------------
// uopc_taylor_cell: one nested Taylor step
// Computes r' = 1 - ((x2 * r) >> 30) / DIVISOR in Q30 over three stages.
// ----------------------------------------------------------------------------
module uopc_taylor_cell
	import uopc_pkg::*;
#(
	parameter int DIVISOR = 6
) (
	input  logic    clk,
	input  taylor_t din,
	output taylor_t dout
);

	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIVISOR);

	logic [62:0] prod;
	logic [63:0] tprod;
	logic [39:0] back;
	logic [39:0] rem;
	logic [32:0] quo;

	logic [30:0] x_s1, x_s2;
	logic [31:0] x2_s1, x2_s2;
	logic neg_s1, neg_s2;
	logic [31:0] n_s1, n_s2;
	logic [31:0] q0_s2;
	taylor_t out_q;

	assign prod = 63'(din.x2) * 63'(din.r);
	assign tprod = 64'(n_s1) * 64'(RECIP);
	assign back = 40'(q0_s2) * 40'(DIVISOR);
	assign rem = 40'(n_s2) - back;
	assign quo = 33'(q0_s2) + ((rem >= 40'(DIVISOR)) ? 33'd1 : 33'd0);

	always_ff @(posedge clk) begin
		x_s1 <= din.x;
		x2_s1 <= din.x2;
		neg_s1 <= din.neg;
		n_s1 <= prod[61:30];
		x_s2 <= x_s1;
		x2_s2 <= x2_s1;
		neg_s2 <= neg_s1;
		n_s2 <= n_s1;
		q0_s2 <= tprod[63:32];
		out_q.x <= x_s2;
		out_q.x2 <= x2_s2;
		out_q.neg <= neg_s2;
		out_q.r <= 31'(33'(ONE_Q30) - quo);
	end

	assign dout = out_q;

endmodule

// ----- rtl/core/uopc_sine.sv -----
// ----------------------------------------------------------------------------
// uopc_sine: pipelined sine of a binary angle
// Folds the angle into a quarter wave, runs a chain of Taylor cells and rounds
// the result to TRIG_BITS fractional bits.
// ----------------------------------------------------------------------------
module uopc_sine
	import uopc_pkg::*;
#(
	parameter int TRIG_BITS = 16
) (
	input  logic                        clk,
	input  logic [15:0]                 angle,
	output logic signed [TRIG_BITS+1:0] value
);

	localparam logic [31:0] RND = 32'd1 << (29 - TRIG_BITS);

	logic [14:0] m;
	logic [48:0] xp;
	logic [61:0] xx;
	logic [61:0] sp;
	logic [31:0] sc;
	logic [31:0] t;

	logic [30:0] x_s1, x_s2;
	logic neg_s1, neg_s2;
	logic [31:0] x2_s2;
	logic [31:0] s_s3;
	logic neg_s3;
	logic signed [TRIG_BITS+1:0] value_s4;

	taylor_t chain [TAYLOR_STEPS+1];

	assign m = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
	assign xp = 49'(m) * 49'(PI_Q32) + 49'd65536;
	assign xx = 62'(x_s1) * 62'(x_s1) + 62'd536870912;

	always_ff @(posedge clk) begin
		x_s1 <= xp[47:17];
		neg_s1 <= angle[15];
		x_s2 <= x_s1;
		neg_s2 <= neg_s1;
		x2_s2 <= xx[61:30];
	end

	assign chain[0] = '{x: x_s2, x2: x2_s2, r: ONE_Q30, neg: neg_s2};

	for (genvar i = 0; i < TAYLOR_STEPS; i++) begin : g_cell
		uopc_taylor_cell #(.DIVISOR(taylor_div(i))) u_cell (
			.clk (clk),
			.din (chain[i]),
			.dout(chain[i+1])
		);
	end

	assign sp = 62'(chain[TAYLOR_STEPS].x) * 62'(chain[TAYLOR_STEPS].r);
	assign sc = (s_s3 > 32'(ONE_Q30)) ? 32'(ONE_Q30) : s_s3;
	assign t = (sc + RND) >> (30 - TRIG_BITS);

	always_ff @(posedge clk) begin
		s_s3 <= sp[61:30];
		neg_s3 <= chain[TAYLOR_STEPS].neg;
		value_s4 <= neg_s3 ? -$signed((TRIG_BITS+2)'(t)) : $signed((TRIG_BITS+2)'(t));
	end

	assign value = value_s4;

endmodule

// ----- rtl/core/uopc_div_cell.sv -----
// ----------------------------------------------------------------------------
// uopc_div_cell: one restoring division step
// Shifts one dividend bit into the remainder and one quotient bit into the word.
// ----------------------------------------------------------------------------
module uopc_div_cell
	import uopc_pkg::*;
(
	input  logic clk,
	input  div_t din,
	output div_t dout
);

	logic [16:0] tr;
	logic [16:0] diff;
	logic ge;
	div_t out_q;

	assign tr = {din.rem, din.word[31]};
	assign ge = tr >= {1'b0, din.dv};
	assign diff = tr - {1'b0, din.dv};

	always_ff @(posedge clk) begin
		out_q.rem <= ge ? diff[15:0] : tr[15:0];
		out_q.word <= {din.word[30:0], ge};
		out_q.dv <= din.dv;
		out_q.neg <= din.neg;
		out_q.ovf <= din.ovf;
		out_q.fw <= din.fw;
		out_q.fw_hit <= din.fw_hit;
	end

	assign dout = out_q;

endmodule

// ----- bench/uopc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uopc_checker: result predictor and scoreboard
// Watches the command, configuration and result ports of the offset-point
// controller, predicts each result in fixed point and compares it field by
// field with what the block returns, in order.
// ----------------------------------------------------------------------------
module uopc_checker
	import uopc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] goal_x,
	input  logic signed [31:0] goal_y,
	input  logic [15:0]        goal_heading,
	input  logic signed [31:0] meas_x,
	input  logic signed [31:0] meas_y,
	input  logic [15:0]        meas_heading,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               done,
	input  logic signed [31:0] forward_speed,
	input  logic signed [31:0] turn_rate,
	input  logic               clipped,
	output int                 pending,
	output int                 failures
);

	typedef struct {
		logic signed [31:0] fw;
		logic signed [31:0] turn;
		logic               clip;
	} command_t;

	command_t cmd_queue[$];
	logic [15:0] gain_q;
	logic [15:0] offset_q;

	function automatic longint round_half_up(input longint v, input int sh);
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint heading_sine(input logic [15:0] a);
		logic [1:0] quad;
		logic [13:0] frac;
		bit [63:0] m, x, x2, r, s;
		longint t;
		quad = a[15:14];
		frac = a[13:0];
		m = quad[0] ? (64'd16384 - frac) : frac;
		x = (m * 64'd13493037705 + (64'd1 << 16)) >> 17;
		x2 = (x * x + (64'd1 << 29)) >> 30;
		r = 64'd1 << 30;
		for (int k = 12; k >= 2; k -= 2) begin
			r = (64'd1 << 30) - ((x2 * r) >> 30) / 64'(k * (k + 1));
		end
		s = (x * r) >> 30;
		if (s > (64'd1 << 30)) begin
			s = 64'd1 << 30;
		end
		t = longint'((s + (64'd1 << 13)) >> 14);
		return quad[1] ? -t : t;
	endfunction

	function automatic longint heading_cosine(input logic [15:0] a);
		return heading_sine(a + 16'd16384);
	endfunction

	function automatic longint saturate(input longint v, inout logic hit);
		if (v > 64'sd2147483647) begin
			hit = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			hit = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic command_t predict_command();
		command_t c;
		longint d, kp, cg, sg, cm, sm, ex, ey, vx, vy, fw, num, turn, n4;
		logic hit;
		hit = 1'b0;
		d = (offset_q == 16'd0) ? 1 : longint'(offset_q);
		kp = longint'(gain_q);
		cg = heading_cosine(goal_heading);
		sg = heading_sine(goal_heading);
		cm = heading_cosine(meas_heading);
		sm = heading_sine(meas_heading);
		ex = (longint'(goal_x) + round_half_up(d * cg, 12))
			- (longint'(meas_x) + round_half_up(d * cm, 12));
		ey = (longint'(goal_y) + round_half_up(d * sg, 12))
			- (longint'(meas_y) + round_half_up(d * sm, 12));
		vx = round_half_up(kp * ex, 12);
		vy = round_half_up(kp * ey, 12);
		fw = round_half_up(cm * vx + sm * vy, 16);
		num = round_half_up(cm * vy - sm * vx, 16);
		n4 = num * 4096;
		if (n4 >= 0) begin
			turn = (n4 + d / 2) / d;
		end else begin
			turn = -((-n4 + d / 2) / d);
		end
		c.fw = 32'(saturate(fw, hit));
		c.turn = 32'(saturate(turn, hit));
		c.clip = hit;
		return c;
	endfunction

	assign pending = cmd_queue.size();

	always @(posedge clk or negedge arst_n) begin
		command_t e;
		if (!arst_n) begin
			gain_q <= 16'd2048;
			offset_q <= 16'd1229;
			cmd_queue.delete();
			failures <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_PROP_GAIN) begin
					gain_q <= cfg_data;
				end else if (cfg_index == REG_POINT_OFFSET) begin
					offset_q <= cfg_data;
				end
			end
			if (done) begin
				if (cmd_queue.size() == 0) begin
					$display("%0t: unexpected result fw=%0d turn=%0d clip=%0b", $time,
						forward_speed, turn_rate, clipped);
					failures <= failures + 1;
				end else begin
					e = cmd_queue.pop_front();
					if (e.fw !== forward_speed || e.turn !== turn_rate
						|| e.clip !== clipped) begin
						$display("%0t: mismatch expected fw=%0d turn=%0d clip=%0b, got fw=%0d turn=%0d clip=%0b",
							$time, e.fw, e.turn, e.clip, forward_speed, turn_rate, clipped);
						failures <= failures + 1;
					end
				end
			end
			if (start && !busy) begin
				cmd_queue.push_back(predict_command());
			end
		end
	end

endmodule

// ----- bench/tb_unicycle_offset_point_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unicycle_offset_point_controller: testbench top
// Drives directed and random pose pairs through several gain and offset
// settings with random idle bursts, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_unicycle_offset_point_controller;
	import uopc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 70;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [31:0] goal_x, goal_y, meas_x, meas_y;
	logic [15:0] goal_heading, meas_heading;
	logic cfg_we;
	logic cfg_index;
	logic [15:0] cfg_data;
	logic done;
	logic signed [31:0] forward_speed, turn_rate;
	logic clipped;
	int pending;
	int failures;
	int cycles;
	bit idling_on;

	unicycle_offset_point_controller dut (.*);

	uopc_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_pose(input logic signed [31:0] gx, gy, input logic [15:0] gh,
		input logic signed [31:0] mx, my, input logic [15:0] mh);
		goal_x <= gx;
		goal_y <= gy;
		goal_heading <= gh;
		meas_x <= mx;
		meas_y <= my;
		meas_heading <= mh;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (idling_on && $urandom_range(3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] value);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
			2: return $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
			default: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
		endcase
	endfunction

	task automatic random_poses(input int count);
		for (int i = 0; i < count; i++) begin
			send_pose(rand_coord(), rand_coord(), 16'($urandom),
				rand_coord(), rand_coord(), 16'($urandom));
		end
	endtask

	initial begin
		cycles <= 0;
		idling_on <= 1'b1;
		arst_n <= 1'b0;
		start <= 1'b0;
		goal_x <= '0;
		goal_y <= '0;
		goal_heading <= '0;
		meas_x <= '0;
		meas_y <= '0;
		meas_heading <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_PROP_GAIN;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pose(0, 0, 16'd0, 0, 0, 16'd0);
		send_pose(32'sh0001_0000, 0, 16'd0, 0, 0, 16'd0);
		send_pose(0, 32'sh0001_0000, 16'd16384, 0, 0, 16'd16384);
		send_pose(0, 0, 16'd32768, 32'sh0002_0000, 0, 16'd32768);
		send_pose(0, 0, 16'd49152, 0, 32'sh0002_0000, 16'd49152);
		send_pose(0, 0, 16'd65535, 0, 0, 16'd8192);
		send_pose(0, 0, 16'd8192, 0, 0, 16'd65535);
		send_pose(32'sh7fff_ffff, 32'sh7fff_ffff, 16'd0,
			32'sh8000_0000, 32'sh8000_0000, 16'd0);
		send_pose(32'sh8000_0000, 32'sh8000_0000, 16'd32768,
			32'sh7fff_ffff, 32'sh7fff_ffff, 16'd24576);
		send_pose(32'sh7fff_ffff, 32'sh8000_0000, 16'hffff,
			32'sh8000_0000, 32'sh7fff_ffff, 16'h0000);
		send_pose(-32'sh0003_0000, 32'sh0005_0000, 16'd40000,
			32'sh0001_0000, -32'sh0002_0000, 16'd12345);

		write_reg(REG_PROP_GAIN, 16'hffff);
		write_reg(REG_POINT_OFFSET, 16'd0);
		send_pose(32'sh7fff_ffff, 0, 16'd0, 32'sh8000_0000, 0, 16'd0);
		send_pose(0, 32'sh7fff_ffff, 16'd0, 0, 32'sh8000_0000, 16'd16384);
		send_pose(32'sh0000_1000, 0, 16'd0, 0, 32'sh0000_1000, 16'd16384);
		send_pose(0, 0, 16'd16384, 0, 0, 16'd0);
		write_reg(REG_POINT_OFFSET, 16'hffff);
		send_pose(32'sh7fff_ffff, 32'sh7fff_ffff, 16'd8192,
			32'sh8000_0000, 32'sh8000_0000, 16'd40960);
		send_pose(0, 0, 16'd0, 0, 0, 16'd32768);
		write_reg(REG_PROP_GAIN, 16'd0);
		write_reg(REG_POINT_OFFSET, 16'd1);
		send_pose(32'sh7fff_ffff, 32'sh7fff_ffff, 16'd1000,
			32'sh8000_0000, 32'sh8000_0000, 16'd30000);
		send_pose(32'sh0001_0000, 0, 16'd0, 0, 0, 16'd0);

		write_reg(REG_PROP_GAIN, 16'd2048);
		write_reg(REG_POINT_OFFSET, 16'd1229);
		random_poses(200);
		write_reg(REG_PROP_GAIN, 16'hffff);
		write_reg(REG_POINT_OFFSET, 16'd0);
		random_poses(150);
		write_reg(REG_PROP_GAIN, 16'd1);
		write_reg(REG_POINT_OFFSET, 16'hffff);
		random_poses(150);
		for (int p = 0; p < 3; p++) begin
			write_reg(REG_PROP_GAIN, 16'($urandom));
			write_reg(REG_POINT_OFFSET, 16'($urandom));
			random_poses(80);
		end
		idling_on <= 1'b0;
		random_poses(200);

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
